FILE: sv/mcs_pkg.sv
// Package with the types, constants and helper functions of the Markov chain sampler.
`timescale 1ns / 1ps

package mcs_pkg;

  // Generator constants
  localparam int unsigned MT_N       = 624;
  localparam int unsigned MT_M       = 397;
  localparam int unsigned MT_IDX_W   = 10;
  localparam logic [31:0] MT_MATRIX  = 32'h9908_B0DF;
  localparam logic [31:0] SEED_MULT  = 32'd1812433253;

  // Field widths fixed by the interface
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ST_W       = 3;
  localparam int unsigned ENTRY_W    = 16;
  localparam int unsigned NUM_W      = 4;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Table dimension, tied to the 3-bit state fields.
  localparam int unsigned MAX_STATES = 8;

  // Item kinds
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SEED      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NUMSTATES = 2'd2;

  localparam logic [31:0]       SEED_RST = 32'd42;
  localparam logic [ST_W-1:0]   INIT_RST = 3'd0;
  localparam logic [NUM_W-1:0]  NUM_RST  = 4'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED0,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_MT_RD0,
    ST_MT_RD1,
    ST_MT_RD2,
    ST_MT_WAIT,
    ST_WALK_RD,
    ST_WALK_ACC,
    ST_EMIT
  } state_e;

  // Output tempering of one generator word.
  function automatic logic [31:0] mt_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Index k places on in the word ring, wrapping at MT_N.
  function automatic logic [MT_IDX_W-1:0] mt_wrap_add(input logic [MT_IDX_W-1:0] p,
                                                       input logic [MT_IDX_W-1:0] k);
    logic [MT_IDX_W:0] s;
    s = {1'b0, p} + {1'b0, k};
    if (s >= (MT_IDX_W+1)'(MT_N)) begin
      s = s - (MT_IDX_W+1)'(MT_N);
    end
    return s[MT_IDX_W-1:0];
  endfunction

endpackage

FILE: sv/mcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mcs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/markov_chain_sampler.sv
// Markov chain sampler driven by a Mersenne Twister word generator.
//
//   channel   | direction | contents
//   s_axis    | in        | tdata: mode, row, column, probability
//   m_axis    | out       | tdata: chain_state; tuser: from_restart
//   cfg       | in        | write only: seed, initial_state, num_states
//
// A load is written to the table when accepted. A restart seeds the 624-word ring
// through one shared multiplier, each further word via a multiply and a write state.
// A step draws and refreshes one ring word, then walks the table row, a read and an
// accumulate state per column, and hands the result over in the emit state; with no
// hit it gives none. The input is not ready while an item is at work. A result waits
// in the output register; if it is still held, the next result waits in turn.
`timescale 1ns / 1ps

module markov_chain_sampler #(
  parameter int unsigned PROB_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,   // mode, row, column, probability
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // chain_state, zero fill
  output logic                           m_axis_tuser,   // from_restart
  input  logic                           cfg_we_i,
  input  logic [mcs_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [mcs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import mcs_pkg::*;

  localparam int unsigned SW   = $clog2(MAX_STATES);
  localparam int unsigned CW   = $clog2(MAX_STATES + 1);
  localparam int unsigned TD   = MAX_STATES * MAX_STATES;
  localparam int unsigned TAW  = $clog2(TD);
  localparam int unsigned SUMW = ENTRY_W + SW + 1;
  localparam int unsigned CMPW = (SUMW > PROB_BITS) ? SUMW : PROB_BITS;

  // Input fields
  logic [MODE_W-1:0]  in_mode;
  logic [ST_W-1:0]    in_row;
  logic [ST_W-1:0]    in_col;
  logic [ENTRY_W-1:0] in_prob;
  assign in_mode = s_axis_tdata[1:0];
  assign in_row  = s_axis_tdata[4:2];
  assign in_col  = s_axis_tdata[7:5];
  assign in_prob = s_axis_tdata[23:8];

  // Configuration
  logic [31:0]      seed_q;
  logic [ST_W-1:0]  init_q;
  logic [NUM_W-1:0] nstates_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= SEED_RST;
      init_q    <= INIT_RST;
      nstates_q <= NUM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_SEED:      seed_q    <= cfg_data_i;
        REG_INIT:      init_q    <= cfg_data_i[ST_W-1:0];
        REG_NUMSTATES: nstates_q <= cfg_data_i[NUM_W-1:0];
        default:       ;
      endcase
    end
  end

  state_e state_q, state_d;

  logic [ST_W-1:0]     cur_q;
  logic [MT_IDX_W-1:0] ptr_q;
  logic [MT_IDX_W-1:0] sidx_q;
  logic [31:0]         prev_q;
  logic [31:0]         prod_q;
  logic [31:0]         a_q, b_q;
  logic [31:0]         word_q;
  logic [CW-1:0]       col_q;
  logic [CW-1:0]       n_q;
  logic [SW-1:0]       row_q;
  logic [SUMW-1:0]     sum_q;
  logic [ST_W-1:0]     res_state_q;
  logic                res_restart_q;
  logic                m_valid_q;
  logic [ST_W-1:0]     m_state_q;
  logic                m_restart_q;

  // Memory ports
  logic                mt_we;
  logic [MT_IDX_W-1:0] mt_waddr, mt_raddr;
  logic [31:0]         mt_wdata, mt_rdata;
  logic                tb_we;
  logic [TAW-1:0]      tb_waddr, tb_raddr;
  logic [ENTRY_W-1:0]  tb_rdata;

  logic        accept;
  logic [31:0] seed_val;
  logic [31:0] regen_y;
  logic [31:0] regen_v;
  logic [SUMW-1:0] sum_next;
  logic        hit;
  logic        last_col;
  logic        out_free;
  logic [CW-1:0] n_clamped;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign seed_val = prod_q + 32'(sidx_q);
  assign regen_y  = {a_q[31], b_q[30:0]};
  assign regen_v  = mt_rdata ^ (regen_y >> 1) ^ (regen_y[0] ? MT_MATRIX : 32'd0);
  assign sum_next = sum_q + SUMW'(tb_rdata);
  assign hit      = CMPW'(word_q[31 -: PROB_BITS]) < CMPW'(sum_next);
  assign last_col = (col_q + CW'(1)) == n_q;

  always_comb begin
    if (nstates_q == '0) begin
      n_clamped = CW'(1);
    end else if (32'(nstates_q) > MAX_STATES) begin
      n_clamped = CW'(MAX_STATES);
    end else begin
      n_clamped = CW'(nstates_q);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_mode == MODE_RESTART) begin
          state_d = ST_SEED0;
        end else if (accept && in_mode == MODE_STEP) begin
          state_d = ST_MT_RD0;
        end
      end
      ST_SEED0:    state_d = ST_SEED_MUL;
      ST_SEED_MUL: state_d = ST_SEED_WR;
      ST_SEED_WR:  state_d = (sidx_q == MT_IDX_W'(MT_N - 1)) ? ST_EMIT : ST_SEED_MUL;
      ST_MT_RD0:   state_d = ST_MT_RD1;
      ST_MT_RD1:   state_d = ST_MT_RD2;
      ST_MT_RD2:   state_d = ST_MT_WAIT;
      ST_MT_WAIT:  state_d = ST_WALK_RD;
      ST_WALK_RD:  state_d = ST_WALK_ACC;
      ST_WALK_ACC: begin
        if (hit) begin
          state_d = ST_EMIT;
        end else if (last_col) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      ST_EMIT:     state_d = out_free ? ST_IDLE : ST_EMIT;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and memory controls
  always_comb begin
    s_axis_tready = 1'b0;
    mt_we    = 1'b0;
    mt_waddr = ptr_q;
    mt_wdata = regen_v;
    mt_raddr = ptr_q;
    tb_we    = 1'b0;
    tb_waddr = TAW'(32'(in_row) * MAX_STATES + 32'(in_col));
    tb_raddr = TAW'(32'(row_q) * MAX_STATES + 32'(col_q));
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        tb_we = accept && in_mode == MODE_LOAD &&
                32'(in_row) < MAX_STATES && 32'(in_col) < MAX_STATES;
      end
      ST_SEED0: begin
        mt_we    = 1'b1;
        mt_waddr = '0;
        mt_wdata = seed_q;
      end
      ST_SEED_WR: begin
        mt_we    = 1'b1;
        mt_waddr = sidx_q;
        mt_wdata = seed_val;
      end
      ST_MT_RD0: mt_raddr = ptr_q;
      ST_MT_RD1: mt_raddr = mt_wrap_add(ptr_q, MT_IDX_W'(1));
      ST_MT_RD2: mt_raddr = mt_wrap_add(ptr_q, MT_IDX_W'(MT_M));
      ST_MT_WAIT: mt_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= '0;
      ptr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SEED_WR && state_d == ST_EMIT) begin
        cur_q <= ST_W'(32'(init_q) % MAX_STATES);
        ptr_q <= '0;
      end
      if (state_q == ST_MT_WAIT) begin
        ptr_q <= mt_wrap_add(ptr_q, MT_IDX_W'(1));
      end
      if (state_q == ST_WALK_ACC && hit) begin
        cur_q <= ST_W'(col_q);
      end
      if (state_q == ST_EMIT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        n_q   <= n_clamped;
        row_q <= SW'(32'(cur_q) % MAX_STATES);
      end
      ST_SEED0: begin
        prev_q <= seed_q;
        sidx_q <= MT_IDX_W'(1);
      end
      ST_SEED_MUL: prod_q <= SEED_MULT * (prev_q ^ (prev_q >> 30));
      ST_SEED_WR: begin
        prev_q        <= seed_val;
        sidx_q        <= sidx_q + MT_IDX_W'(1);
        res_state_q   <= ST_W'(32'(init_q) % MAX_STATES);
        res_restart_q <= 1'b1;
      end
      ST_MT_RD1: a_q <= mt_rdata;
      ST_MT_RD2: b_q <= mt_rdata;
      ST_MT_WAIT: begin
        word_q <= mt_temper(regen_v);
        col_q  <= '0;
        sum_q  <= '0;
      end
      ST_WALK_ACC: begin
        sum_q         <= sum_next;
        col_q         <= col_q + CW'(1);
        res_state_q   <= ST_W'(col_q);
        res_restart_q <= 1'b0;
      end
      ST_EMIT: begin
        if (out_free) begin
          m_state_q   <= res_state_q;
          m_restart_q <= res_restart_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_state_q};
  assign m_axis_tuser  = m_restart_q;

  mcs_ram #(.WIDTH(32), .DEPTH(MT_N)) u_mt_ram (
    .clk_i   (clk_i),
    .we_i    (mt_we),
    .waddr_i (mt_waddr),
    .wdata_i (mt_wdata),
    .raddr_i (mt_raddr),
    .rdata_o (mt_rdata)
  );

  mcs_ram #(.WIDTH(ENTRY_W), .DEPTH(TD)) u_tb_ram (
    .clk_i   (clk_i),
    .we_i    (tb_we),
    .waddr_i (tb_waddr),
    .wdata_i (in_prob),
    .raddr_i (tb_raddr),
    .rdata_o (tb_rdata)
  );

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q < MT_IDX_W'(MT_N))
    else $error("draw pointer left the word ring");

  a_seed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEED_WR |-> sidx_q < MT_IDX_W'(MT_N) && sidx_q != '0)
    else $error("seeding index out of range");

  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK_RD |-> col_q < n_q && 32'(n_q) <= MAX_STATES)
    else $error("column walk beyond the states in use");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MT_WAIT |=> !s_axis_tready && state_q == ST_WALK_RD)
    else $error("step did not proceed to the column walk");
`endif

endmodule
